[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define WPR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen outside reset.
`define WPR_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

[hw/rtl/wpr_pkg.sv]
package wpr_pkg;

    localparam int AGE_W      = 8;
    localparam int WEIGHT_W   = 8;
    localparam int SUM_W      = 11;
    localparam int FRAC_W     = 16;
    localparam int TARGET_W   = SUM_W + FRAC_W;
    localparam int CTX_REQ_W  = 4;
    localparam int OUTCOME_W  = 3;
    localparam int COUNT_W    = 4;
    localparam int WINDOW_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int OUTCOMES_DEF = 8;
    localparam int CONTEXTS_DEF = 16;
    localparam int MAX_AGE_DEF  = 255;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_RECENCY_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OUTCOME_COUNT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_LOW    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHTS_HIGH   = CFG_IDX_W'(3);

endpackage

[hw/rtl/wpr_req_if.sv]
interface wpr_req_if;
    logic                           valid;
    logic                           ready;
    logic [wpr_pkg::CTX_REQ_W-1:0]  context_req;
    logic [wpr_pkg::FRAC_W-1:0]     random_fraction;

    modport source (output valid, output context_req, output random_fraction, input ready);
    modport sink   (input valid, input context_req, input random_fraction, output ready);
endinterface

[hw/rtl/wpr_rsp_if.sv]
interface wpr_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [wpr_pkg::OUTCOME_W-1:0]  pick_index;
    logic                           none_eligible;

    modport source (output valid, output pick_index, output none_eligible, input ready);
    modport sink   (input valid, input pick_index, input none_eligible, output ready);
endinterface

[hw/rtl/wpr_cfg_if.sv]
interface wpr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wpr_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [wpr_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[hw/rtl/weighted_pick_with_recency_filter.sv]
// Weighted pick with recency filter.
// req (sink): context_req selects a history context, random_fraction is a
//   uniform fraction in units of 1/65536. One transaction is one draw.
// rsp (source): pick_index and none_eligible, one transaction per draw.
// cfg (sink): register writes (0 recency window, 1 outcome count, 2/3 packed
//   weights), always ready; only write while no draw is in flight.
// Steps: a draw reads the context's ages from the age memory (one read port,
//   one age per cycle), multiplies the fraction by the eligible weight total,
//   scans the cumulative weights up to the outcome count (skipped when none is
//   eligible), writes all OUTCOMES ages back and hands off the result. The age
//   memory port dominates the draw time; req.ready is high only between draws,
//   so a new draw is taken only after the last one has handed off its result.
// The result sits in an output register; the next draw starts while it waits,
//   and only its own hand-off waits for rsp.ready.
// Reset: all ages read as MAX_AGE through per-context valid bits (no clearing
//   pass), recency window 0, outcome count 8, weights 0.
`include "assert_macros.svh"

module weighted_pick_with_recency_filter #(
    parameter int OUTCOMES = wpr_pkg::OUTCOMES_DEF,
    parameter int CONTEXTS = wpr_pkg::CONTEXTS_DEF,
    parameter int MAX_AGE  = wpr_pkg::MAX_AGE_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    wpr_req_if.sink   req,
    wpr_rsp_if.source rsp,
    wpr_cfg_if.sink   cfg
);

    localparam int JW        = $clog2(OUTCOMES);
    localparam int CW        = $clog2(OUTCOMES + 1);
    localparam int CTX_W     = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int AW        = CTX_W + JW;
    localparam int MEM_DEPTH = CONTEXTS * (2 ** JW);
    localparam int CTX_REQ_N = 2 ** wpr_pkg::CTX_REQ_W;
    localparam int AGE_W     = wpr_pkg::AGE_W;
    localparam int SUM_W     = wpr_pkg::SUM_W;
    localparam int WEIGHT_W  = wpr_pkg::WEIGHT_W;
    localparam int COUNT_W   = wpr_pkg::COUNT_W;

    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_AGE);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [CTX_W-1:0]               ctx_reg, ctx_next;
    logic [wpr_pkg::FRAC_W-1:0]     frac_reg, frac_next;
    logic [SUM_W-1:0]               total_reg, total_next;
    logic [SUM_W-1:0]               running_reg, running_next;
    logic [wpr_pkg::TARGET_W-1:0]   target_reg, target_next;
    logic                           any_reg, any_next;
    logic [OUTCOMES-1:0]            elig_reg, elig_next;
    logic [JW-1:0]                  chosen_reg, chosen_next;
    logic [CONTEXTS-1:0]            row_valid_reg, row_valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic [wpr_pkg::OUTCOME_W-1:0]  out_chosen_reg, out_chosen_next;
    logic                           out_none_reg, out_none_next;
    logic [wpr_pkg::WINDOW_W-1:0]   window_reg, window_next;
    logic [COUNT_W-1:0]             count_reg, count_next;
    logic [wpr_pkg::CFG_DATA_W-1:0] weights_low_reg, weights_low_next;
    logic [wpr_pkg::CFG_DATA_W-1:0] weights_high_reg, weights_high_next;

    logic [AGE_W-1:0]   age_reg [OUTCOMES];
    logic               age_we;
    logic [JW-1:0]      age_widx;
    logic [AGE_W-1:0]   age_wdata;

    logic [AGE_W-1:0]   age_mem [MEM_DEPTH];
    logic [AGE_W-1:0]   rd_data_reg;
    logic [AW-1:0]      mem_addr;
    logic               mem_we;
    logic [AGE_W-1:0]   mem_wdata;

    logic [CTX_W-1:0]   ctx_lut [CTX_REQ_N];
    logic [COUNT_W-1:0] n_cur;
    logic [JW-1:0]      ld_idx;
    logic [JW-1:0]      cnt_idx;
    logic [JW-1:0]      w_idx;
    logic [WEIGHT_W-1:0] w_cur;
    logic [AGE_W-1:0]   ld_age;
    logic [SUM_W-1:0]   run_sum;
    logic [AGE_W-1:0]   upd_age;
    logic [2*wpr_pkg::CFG_DATA_W-1:0] weights_all;

    // context_req modulo CONTEXTS, resolved at elaboration
    for (genvar gi = 0; gi < CTX_REQ_N; gi++)
    begin : g_ctx_lut
        assign ctx_lut[gi] = CTX_W'(gi % CONTEXTS);
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            n_cur = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(OUTCOMES))
        begin
            n_cur = COUNT_W'(OUTCOMES);
        end
        else
        begin
            n_cur = count_reg;
        end
    end

    assign cnt_idx     = cnt_reg[JW-1:0];
    assign ld_idx      = JW'(cnt_reg - CW'(1));
    assign w_idx       = (state_reg == ST_LOAD) ? ld_idx : cnt_idx;
    assign weights_all = {weights_high_reg, weights_low_reg};
    assign w_cur       = weights_all[WEIGHT_W * int'(w_idx) +: WEIGHT_W];
    assign ld_age      = row_valid_reg[ctx_reg] ? rd_data_reg : AGE_MAX;
    assign run_sum     = running_reg + (elig_reg[cnt_idx] ? SUM_W'(w_cur) : SUM_W'(0));
    assign upd_age     = (cnt_idx == chosen_reg) ? AGE_W'(0) : age_reg[cnt_idx];
    assign mem_addr    = {ctx_reg, cnt_idx};

    assign req.ready          = (state_reg == ST_IDLE);
    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_valid_reg;
    assign rsp.pick_index     = out_chosen_reg;
    assign rsp.none_eligible  = out_none_reg;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        ctx_next          = ctx_reg;
        frac_next         = frac_reg;
        total_next        = total_reg;
        running_next      = running_reg;
        target_next       = target_reg;
        any_next          = any_reg;
        elig_next         = elig_reg;
        chosen_next       = chosen_reg;
        row_valid_next    = row_valid_reg;
        out_valid_next    = out_valid_reg;
        out_chosen_next   = out_chosen_reg;
        out_none_next     = out_none_reg;
        window_next       = window_reg;
        count_next        = count_reg;
        weights_low_next  = weights_low_reg;
        weights_high_next = weights_high_reg;
        age_we            = 1'b0;
        age_widx          = ld_idx;
        age_wdata         = ld_age;
        mem_we            = 1'b0;
        mem_wdata         = upd_age;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                wpr_pkg::REG_RECENCY_WINDOW: window_next = cfg.wdata[wpr_pkg::WINDOW_W-1:0];
                wpr_pkg::REG_OUTCOME_COUNT:  count_next = cfg.wdata[COUNT_W-1:0];
                wpr_pkg::REG_WEIGHTS_LOW:    weights_low_next = cfg.wdata;
                wpr_pkg::REG_WEIGHTS_HIGH:   weights_high_next = cfg.wdata;
                default:                     window_next = window_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    ctx_next   = ctx_lut[req.context_req];
                    frac_next  = req.random_fraction;
                    cnt_next   = '0;
                    total_next = '0;
                    any_next   = 1'b0;
                    elig_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                // read data is registered, so it arrives in the cycle after its address
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg != '0)
                begin
                    age_we = 1'b1;
                    if ((COUNT_W'(cnt_reg) <= n_cur) && (ld_age > window_reg))
                    begin
                        elig_next[ld_idx] = 1'b1;
                        total_next        = total_reg + SUM_W'(w_cur);
                        any_next          = 1'b1;
                    end
                end
                if (cnt_reg == CW'(OUTCOMES))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                target_next  = wpr_pkg::TARGET_W'(frac_reg) * wpr_pkg::TARGET_W'(total_reg);
                cnt_next     = '0;
                running_next = '0;
                chosen_next  = JW'(n_cur - COUNT_W'(1));
                state_next   = any_reg ? ST_SCAN : ST_UPD;
            end
            ST_SCAN:
            begin
                running_next = run_sum;
                if (elig_reg[cnt_idx] &&
                    ({run_sum, wpr_pkg::FRAC_W'(0)} >= target_reg))
                begin
                    chosen_next = cnt_idx;
                    cnt_next    = '0;
                    state_next  = ST_UPD;
                end
                else if ((COUNT_W'(cnt_reg) + COUNT_W'(1)) >= n_cur)
                begin
                    cnt_next   = '0;
                    state_next = ST_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_UPD:
            begin
                // outcomes beyond the count keep their age, but are still
                // written so a fresh row is fully defined
                mem_we = 1'b1;
                if ((COUNT_W'(cnt_reg) < n_cur) && (upd_age < AGE_MAX))
                begin
                    mem_wdata = upd_age + AGE_W'(1);
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(OUTCOMES - 1))
                begin
                    row_valid_next[ctx_reg] = 1'b1;
                    state_next              = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_chosen_next = wpr_pkg::OUTCOME_W'(chosen_reg);
                    out_none_next   = !any_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            ctx_reg          <= '0;
            frac_reg         <= '0;
            total_reg        <= '0;
            running_reg      <= '0;
            target_reg       <= '0;
            any_reg          <= 1'b0;
            elig_reg         <= '0;
            chosen_reg       <= '0;
            row_valid_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_chosen_reg   <= '0;
            out_none_reg     <= 1'b0;
            window_reg       <= '0;
            count_reg        <= wpr_pkg::COUNT_RESET;
            weights_low_reg  <= '0;
            weights_high_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            ctx_reg          <= ctx_next;
            frac_reg         <= frac_next;
            total_reg        <= total_next;
            running_reg      <= running_next;
            target_reg       <= target_next;
            any_reg          <= any_next;
            elig_reg         <= elig_next;
            chosen_reg       <= chosen_next;
            row_valid_reg    <= row_valid_next;
            out_valid_reg    <= out_valid_next;
            out_chosen_reg   <= out_chosen_next;
            out_none_reg     <= out_none_next;
            window_reg       <= window_next;
            count_reg        <= count_next;
            weights_low_reg  <= weights_low_next;
            weights_high_reg <= weights_high_next;
        end
    end

    // local copy of the context's ages
    always_ff @(posedge clk)
    begin
        if (age_we)
        begin
            age_reg[age_widx] <= age_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            age_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= age_mem[mem_addr];
    end

    `WPR_ASSERT(a_accept_starts_load, clk, rst_n, (req.valid && req.ready) |=> (state_reg == ST_LOAD))
    `WPR_ASSERT(a_chosen_in_use, clk, rst_n, (state_reg == ST_UPD) |-> (COUNT_W'(chosen_reg) < n_cur))
    `WPR_ASSERT(a_none_picks_last, clk, rst_n, ((state_reg == ST_DONE) && !any_reg) |-> (COUNT_W'(chosen_reg) == (n_cur - COUNT_W'(1))))
    `WPR_NEVER(a_target_bounded, clk, rst_n, (state_reg == ST_SCAN) && (target_reg > {total_reg, wpr_pkg::FRAC_W'(0)}))

endmodule
